[rtl/core/i2cms_pkg.sv]
`default_nettype none

package i2cms_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int LEN_W        = 5;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_EVENT = 2'd2;

	localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_TX_LENGTH      = 2'd1;
	localparam logic [1:0] REG_RX_LENGTH      = 2'd2;
	localparam logic [1:0] REG_READ_MODE      = 2'd3;

	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
	localparam logic [7:0] ST_ADDR_W_NAK = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
	localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
	localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_R_NAK = 8'h58;
	localparam logic [7:0] READ_BIT      = 8'h01;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] load_index;
		logic [7:0] load_byte;
		logic [7:0] status_code;
		logic [7:0] bus_byte;
		logic       timeout_flag;
	} in_item_t;

	typedef struct packed {
		logic       data_write;
		logic [7:0] data_out;
		logic       ctl_start;
		logic       ctl_stop;
		logic       ctl_ack;
		logic       ctl_clear_si;
		logic       clear_timeout;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       success;
	} out_item_t;

	typedef struct packed {
		logic [7:0]       device_address;
		logic [LEN_W-1:0] tx_length;
		logic [LEN_W-1:0] rx_length;
		logic             read_mode;
	} cfg_t;

	function automatic cnt_t lim(input logic [LEN_W-1:0] v);
		if (int'(v) > BUFFER_DEPTH) begin
			return CNT_W'(BUFFER_DEPTH);
		end
		return CNT_W'(v);
	endfunction

endpackage

`default_nettype wire

[rtl/core/i2cms_step.sv]
`default_nettype none

module i2cms_step (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  i2cms_pkg::in_item_t   item,
	input  i2cms_pkg::cfg_t       cfg,
	output i2cms_pkg::out_item_t  result
);
	import i2cms_pkg::*;

	logic [7:0] byte_buffer [BUFFER_DEPTH];
	cnt_t       byte_count_q;
	logic       end_flag_q;
	logic       success_flag_q;

	cnt_t       count_d;
	logic       end_d;
	logic       success_d;
	logic       buf_we;
	logic [BUF_AW-1:0] buf_addr;
	logic [7:0] buf_wdata;
	cnt_t       txl;
	cnt_t       rxl;
	logic       room;
	logic [7:0] head_byte;
	cnt_t       count_inc;

	always_comb begin
		txl       = lim(cfg.tx_length);
		rxl       = lim(cfg.rx_length);
		room      = byte_count_q < CNT_W'(BUFFER_DEPTH);
		head_byte = room ? byte_buffer[byte_count_q[BUF_AW-1:0]] : 8'h00;
		count_inc = room ? byte_count_q + cnt_t'(1) : byte_count_q;
	end

	always_comb begin
		count_d   = byte_count_q;
		end_d     = end_flag_q;
		success_d = success_flag_q;
		buf_we    = 1'b0;
		buf_addr  = byte_count_q[BUF_AW-1:0];
		buf_wdata = item.bus_byte;
		result    = '0;
		case (item.mode)
			MODE_LOAD: begin
				if (int'(item.load_index) < BUFFER_DEPTH) begin
					buf_we    = 1'b1;
					buf_addr  = BUF_AW'(item.load_index);
					buf_wdata = item.load_byte;
				end
			end
			MODE_START: begin
				count_d          = '0;
				end_d            = 1'b0;
				success_d        = 1'b0;
				result.ctl_start = 1'b1;
			end
			MODE_EVENT: begin
				if (item.timeout_flag) begin
					result.clear_timeout = 1'b1;
				end else if (cfg.read_mode) begin
					case (item.status_code)
						ST_START: begin
							result.data_write   = 1'b1;
							result.data_out     = cfg.device_address;
							result.ctl_clear_si = 1'b1;
						end
						ST_ADDR_W_ACK: begin
							result.data_write   = 1'b1;
							result.data_out     = head_byte;
							result.ctl_clear_si = 1'b1;
							count_d             = count_inc;
						end
						ST_ADDR_W_NAK: begin
							result.ctl_stop     = 1'b1;
							result.ctl_clear_si = 1'b1;
							end_d               = 1'b1;
						end
						ST_DATA_W_ACK: begin
							result.ctl_clear_si = 1'b1;
							if (byte_count_q < txl) begin
								result.data_write = 1'b1;
								result.data_out   = head_byte;
								count_d           = count_inc;
							end else begin
								result.ctl_start = 1'b1;
							end
						end
						ST_RESTART: begin
							result.data_write   = 1'b1;
							result.data_out     = cfg.device_address | READ_BIT;
							result.ctl_clear_si = 1'b1;
						end
						ST_ADDR_R_ACK: begin
							count_d             = '0;
							result.ctl_ack      = rxl != '0;
							result.ctl_clear_si = 1'b1;
						end
						ST_DATA_R_ACK: begin
							result.rx_valid     = 1'b1;
							result.rx_byte      = item.bus_byte;
							buf_we              = room;
							count_d             = count_inc;
							result.ctl_ack      = count_inc < rxl;
							result.ctl_clear_si = 1'b1;
						end
						ST_DATA_R_NAK: begin
							result.rx_valid     = 1'b1;
							result.rx_byte      = item.bus_byte;
							buf_we              = room;
							count_d             = count_inc;
							result.ctl_stop     = 1'b1;
							result.ctl_clear_si = 1'b1;
							success_d           = 1'b1;
							end_d               = 1'b1;
						end
						default: begin
							end_d = 1'b1;
						end
					endcase
				end else begin
					case (item.status_code)
						ST_START: begin
							result.data_write   = 1'b1;
							result.data_out     = cfg.device_address;
							result.ctl_clear_si = 1'b1;
						end
						ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
							result.ctl_clear_si = 1'b1;
							if ((item.status_code == ST_ADDR_W_ACK && txl != '0)
								|| (item.status_code == ST_DATA_W_ACK
								&& byte_count_q < txl)) begin
								result.data_write = 1'b1;
								result.data_out   = head_byte;
								count_d           = count_inc;
							end else begin
								result.ctl_stop = 1'b1;
								success_d       = 1'b1;
								end_d           = 1'b1;
							end
						end
						default: begin
							result.ctl_stop     = 1'b1;
							result.ctl_clear_si = 1'b1;
							end_d               = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		result.done_res = end_d;
		result.success  = success_d;
	end

	always_ff @(posedge clk) begin
		if (step && buf_we) begin
			byte_buffer[buf_addr] <= buf_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			end_flag_q     <= 1'b0;
			success_flag_q <= 1'b0;
		end else if (step) begin
			byte_count_q   <= count_d;
			end_flag_q     <= end_d;
			success_flag_q <= success_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/i2c_master_status_sequencer.sv]
// I2C master status sequencer.
// Input channel (in_valid / in_stall / in_item): items load a transmit
// byte, start a transfer, hand over a bus status event or do nothing.
// Output channel (out_valid / out_stall / out_item): exactly one result
// item per input item, in order, carrying the control requests for the bus
// controller, a received byte and the end and success flags.
// Configuration: cfg_write_en, cfg_index and cfg_data write device_address,
// tx_length, rx_length and read_mode; write only while the block is idle.
// The result is registered: the decode runs while the item sits in the
// input register and loads the result register when the item advances.
// Throughput: one item per cycle while out_stall is low; the byte buffer
// takes one read and one write per cycle, so consecutive events never
// wait on each other.
// Reset clears the byte count, the flags, the configuration registers and
// both valid bits; the byte buffer holds no defined value until written.
// When out_stall is high with a result valid, the result holds, the input
// register keeps its item and in_stall rises until the result is taken.
`default_nettype none

module i2c_master_status_sequencer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  i2cms_pkg::in_item_t   in_item,
	output logic                  out_valid,
	input  wire                   out_stall,
	output i2cms_pkg::out_item_t  out_item,
	input  wire                   cfg_write_en,
	input  wire  [1:0]            cfg_index,
	input  wire  [7:0]            cfg_data
);
	import i2cms_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	logic      accept;
	out_item_t result;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	i2cms_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data;
				REG_TX_LENGTH:      cfg_q.tx_length      <= cfg_data[LEN_W-1:0];
				REG_RX_LENGTH:      cfg_q.rx_length      <= cfg_data[LEN_W-1:0];
				REG_READ_MODE:      cfg_q.read_mode      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_item <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[test/i2c_master_status_sequencer_test.sv]
`timescale 1ns / 1ps

module i2c_master_status_sequencer_test;
	import i2cms_pkg::*;

	localparam int RUN_LIMIT   = 1000000;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 115;

	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
	localparam logic [7:0] ST_DATA_W_NAK = 8'h30;
	localparam logic [7:0] ST_UNKNOWN    = 8'hFF;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      in_valid     = 1'b0;
	logic      in_stall;
	in_item_t  in_item      = '0;
	logic      out_valid;
	logic      out_stall    = 1'b0;
	out_item_t out_item;
	logic       cfg_write_en = 1'b0;
	logic [1:0] cfg_index    = '0;
	logic [7:0] cfg_data     = '0;

	i2c_master_status_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// sequencer image
	logic [7:0] xfer_buf [BUFFER_DEPTH];
	int         xfer_count = 0;
	logic       xfer_done  = 1'b0;
	logic       xfer_ok    = 1'b0;
	logic [7:0] dev_addr   = '0;
	logic [4:0] tx_len     = '0;
	logic [4:0] rx_len     = '0;
	logic       rd_mode    = 1'b0;

	in_item_t  item_backlog [$];
	out_item_t pending_actions [$];
	out_item_t want_actions;

	int in_pct     = 0;
	int out_pct    = 0;
	int gap_left   = 0;
	int stall_left = 0;
	int queued     = 0;
	int errors     = 0;
	int cycles     = 0;
	logic took;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int cap_len(logic [4:0] v);
		return (int'(v) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(v);
	endfunction

	function automatic logic [7:0] next_tx_byte();
		logic [7:0] b;
		b = 8'h00;
		if (xfer_count < BUFFER_DEPTH) begin
			b = xfer_buf[xfer_count];
			xfer_count++;
		end
		return b;
	endfunction

	function automatic void keep_rx_byte(logic [7:0] b);
		if (xfer_count < BUFFER_DEPTH) begin
			xfer_buf[xfer_count] = b;
			xfer_count++;
		end
	endfunction

	function automatic out_item_t next_bus_actions(in_item_t it);
		out_item_t r;
		int txl;
		int rxl;
		r = '0;
		txl = cap_len(tx_len);
		rxl = cap_len(rx_len);
		case (it.mode)
			MODE_LOAD: begin
				xfer_buf[it.load_index] = it.load_byte;
			end
			MODE_START: begin
				xfer_count = 0;
				xfer_done = 1'b0;
				xfer_ok = 1'b0;
				r.ctl_start = 1'b1;
			end
			MODE_EVENT: begin
				if (it.timeout_flag) begin
					r.clear_timeout = 1'b1;
				end else if (rd_mode) begin
					case (it.status_code)
						ST_START: begin
							r.data_write = 1'b1;
							r.data_out = dev_addr;
							r.ctl_clear_si = 1'b1;
						end
						ST_ADDR_W_ACK: begin
							r.data_write = 1'b1;
							r.data_out = next_tx_byte();
							r.ctl_clear_si = 1'b1;
						end
						ST_ADDR_W_NAK: begin
							r.ctl_stop = 1'b1;
							r.ctl_clear_si = 1'b1;
							xfer_done = 1'b1;
						end
						ST_DATA_W_ACK: begin
							if (xfer_count < txl) begin
								r.data_write = 1'b1;
								r.data_out = next_tx_byte();
							end else begin
								r.ctl_start = 1'b1;
							end
							r.ctl_clear_si = 1'b1;
						end
						ST_RESTART: begin
							r.data_write = 1'b1;
							r.data_out = dev_addr | READ_BIT;
							r.ctl_clear_si = 1'b1;
						end
						ST_ADDR_R_ACK: begin
							xfer_count = 0;
							r.ctl_ack = (rxl > 0);
							r.ctl_clear_si = 1'b1;
						end
						ST_DATA_R_ACK: begin
							r.rx_valid = 1'b1;
							r.rx_byte = it.bus_byte;
							keep_rx_byte(it.bus_byte);
							r.ctl_ack = (xfer_count < rxl);
							r.ctl_clear_si = 1'b1;
						end
						ST_DATA_R_NAK: begin
							r.rx_valid = 1'b1;
							r.rx_byte = it.bus_byte;
							keep_rx_byte(it.bus_byte);
							r.ctl_stop = 1'b1;
							r.ctl_clear_si = 1'b1;
							xfer_ok = 1'b1;
							xfer_done = 1'b1;
						end
						default: begin
							xfer_done = 1'b1;
						end
					endcase
				end else begin
					case (it.status_code)
						ST_START: begin
							r.data_write = 1'b1;
							r.data_out = dev_addr;
							r.ctl_clear_si = 1'b1;
						end
						ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
							if ((it.status_code == ST_ADDR_W_ACK && txl > 0) ||
							    (it.status_code == ST_DATA_W_ACK && xfer_count < txl)) begin
								r.data_write = 1'b1;
								r.data_out = next_tx_byte();
							end else begin
								r.ctl_stop = 1'b1;
								xfer_ok = 1'b1;
								xfer_done = 1'b1;
							end
							r.ctl_clear_si = 1'b1;
						end
						default: begin
							r.ctl_stop = 1'b1;
							r.ctl_clear_si = 1'b1;
							xfer_done = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		r.done_res = xfer_done;
		r.success = xfer_ok;
		return r;
	endfunction

	function automatic int draw_gap(int pct);
		if ($urandom_range(99) >= pct) begin
			return 0;
		end
		if ($urandom_range(9) == 0) begin
			return $urandom_range(40, 12);
		end
		return $urandom_range(3, 1);
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 45;
		endcase
	endfunction

	function automatic string show_actions(out_item_t r);
		return $sformatf({"dw=%0d dout=%02h sta=%0d sto=%0d ack=%0d si=%0d ctmo=%0d ",
			"rxv=%0d rxb=%02h done=%0d ok=%0d"}, r.data_write, r.data_out, r.ctl_start,
			r.ctl_stop, r.ctl_ack, r.ctl_clear_si, r.clear_timeout, r.rx_valid, r.rx_byte,
			r.done_res, r.success);
	endfunction

	task automatic note_mismatch(string what, out_item_t want, out_item_t got);
		errors++;
		if (errors <= 10) begin
			$display("mismatch (%s): expected %s", what, show_actions(want));
			$display("                 actual   %s", show_actions(got));
		end
	endtask

	// driver: hold a stalled item, otherwise gap or advance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			gap_left = 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				pending_actions.push_back(next_bus_actions(in_item));
				gap_left = draw_gap(in_pct);
			end
			if (!in_valid || took) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (item_backlog.size() > 0) begin
					in_item <= item_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_actions.size() == 0) begin
					note_mismatch("no item expected", '0, out_item);
				end else begin
					want_actions = pending_actions.pop_front();
					if (out_item !== want_actions) begin
						note_mismatch("field", want_actions, out_item);
					end
				end
			end
			if (stall_left == 0) begin
				stall_left = draw_gap(out_pct);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic in_item_t rand_item();
		logic [31:0] bits;
		bits = $urandom;
		return bits[$bits(in_item_t)-1:0];
	endfunction

	function automatic void queue_item(in_item_t it);
		item_backlog.push_back(it);
		if (it.mode != MODE_UNUSED) begin
			queued++;
		end
	endfunction

	function automatic void add_load(logic [3:0] idx, logic [7:0] b);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_LOAD;
		it.load_index = idx;
		it.load_byte = b;
		queue_item(it);
	endfunction

	function automatic void add_start();
		in_item_t it;
		it = rand_item();
		it.mode = MODE_START;
		queue_item(it);
	endfunction

	function automatic void add_event(logic [7:0] code, logic tmo);
		in_item_t it;
		it = rand_item();
		it.mode = MODE_EVENT;
		it.status_code = code;
		it.timeout_flag = tmo;
		queue_item(it);
	endfunction

	function automatic void add_unused();
		in_item_t it;
		it = rand_item();
		it.mode = MODE_UNUSED;
		queue_item(it);
	endfunction

	// one bus transfer as the controller would report it, sometimes broken
	function automatic void add_transfer();
		logic [7:0] codes [$];
		int txl;
		int rxl;
		int n;
		int pos;
		txl = cap_len(tx_len);
		rxl = cap_len(rx_len);
		codes = {ST_START, ST_ADDR_W_ACK};
		n = rd_mode ? ((txl > 0) ? txl : 1) : txl;
		repeat (n) codes.push_back(ST_DATA_W_ACK);
		if (rd_mode) begin
			codes.push_back(ST_RESTART);
			codes.push_back(ST_ADDR_R_ACK);
			repeat (rxl) codes.push_back(ST_DATA_R_ACK);
			codes.push_back(ST_DATA_R_NAK);
		end
		if ($urandom_range(7) == 0) begin
			pos = int'($urandom_range(codes.size() - 1));
			case ($urandom_range(3))
				0: codes[pos] = ST_ADDR_W_NAK;
				1: codes[pos] = ST_DATA_W_NAK;
				2: codes[pos] = 8'($urandom_range(255));
				default: begin
					while (codes.size() > pos) void'(codes.pop_back());
				end
			endcase
		end
		repeat ($urandom_range(2)) add_load(4'($urandom_range(15)), 8'($urandom_range(255)));
		if ($urandom_range(19) != 0) begin
			add_start();
		end
		foreach (codes[k]) begin
			if ($urandom_range(24) == 0) begin
				add_event(8'($urandom_range(255)), 1'b1);
			end
			add_event(codes[k], 1'b0);
		end
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic set_config(logic [7:0] a, logic [4:0] t, logic [4:0] r, logic m);
		write_reg(REG_DEVICE_ADDRESS, a);
		write_reg(REG_TX_LENGTH, {3'b000, t});
		write_reg(REG_RX_LENGTH, {3'b000, r});
		write_reg(REG_READ_MODE, {7'b0000000, m});
		dev_addr = a;
		tx_len = t;
		rx_len = r;
		rd_mode = m;
		@(negedge clk);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (item_backlog.size() > 0 || in_valid || pending_actions.size() > 0);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_config(8'hFF, 5'd0, 5'd0, 1'b0);
		for (int i = 0; i < BUFFER_DEPTH; i++) begin
			add_load(4'(i), (i == 0) ? 8'h00 :
				(i == BUFFER_DEPTH - 1) ? 8'hFF : 8'($urandom_range(255)));
		end
		add_unused();
		add_start();
		add_event(ST_START, 1'b1);
		add_event(ST_START, 1'b0);
		add_event(ST_ADDR_W_ACK, 1'b0);
		add_event(ST_DATA_W_ACK, 1'b0);
		add_event(ST_UNKNOWN, 1'b0);
		add_event(ST_ADDR_W_NAK, 1'b0);
		drain();

		set_config(8'h00, 5'd1, 5'd0, 1'b1);
		add_start();
		add_event(ST_START, 1'b0);
		add_event(ST_ADDR_W_NAK, 1'b0);
		add_start();
		add_event(ST_START, 1'b0);
		add_event(ST_ADDR_W_ACK, 1'b0);
		add_event(ST_DATA_W_ACK, 1'b0);
		add_event(ST_RESTART, 1'b0);
		add_event(ST_ADDR_R_ACK, 1'b0);
		add_event(ST_DATA_R_NAK, 1'b0);
		add_event(ST_BUS_ERROR, 1'b0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(8'h00, 5'd0, 5'd0, 1'b0);
				1: set_config(8'hFF, 5'd16, 5'd16, 1'b1);
				2: set_config(8'hA5, 5'd16, 5'd0, 1'b0);
				3: set_config(8'h5A, 5'd0, 5'd16, 1'b1);
				default: set_config(8'($urandom_range(255)), 5'($urandom_range(16)),
					5'($urandom_range(16)), 1'($urandom_range(1)));
			endcase
			in_pct = pick_pct();
			out_pct = pick_pct();
			if (p == 5) begin
				in_pct = 0;
				out_pct = 0;
			end
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				if ($urandom_range(9) == 0) begin
					queue_item(rand_item());
				end else begin
					add_transfer();
				end
			end
			drain();
		end

		errors += pending_actions.size();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
